>>> rtl/core/aabb_affine_transform_assert.svh
// Assertion macros used by the checker of the box transform block.
// Needs nothing but a clock and an active-low reset in the calling scope.
`ifndef AABB_AFFINE_TRANSFORM_ASSERT_SVH
`define AABB_AFFINE_TRANSFORM_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define AAT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define AAT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/aat_pkg.sv
// Shared types and constants of the box transform block.
// No dependencies; used by the top level and its checker.
package aat_pkg;

  localparam int PADDR_W  = 6;
  localparam int PDATA_W  = 64;
  localparam int COEF_W   = 32;
  localparam int NUM_REGS = 6;
  localparam int ROWS     = 3;

  typedef logic [PDATA_W-1:0] aat_cfg_t;

  typedef enum logic [2:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW2_C01 = 3'd4,
    REG_ROW2_C23 = 3'd5
  } aat_reg_e;

  // Identity matrix with 16 fraction bits, no translation.
  localparam aat_cfg_t CFG_RESET [NUM_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0, 64'd0, 64'd65536
  };

endpackage

>>> rtl/core/aat_box_if.sv
// Input channel of the box transform block: one box per item.
// Standalone; the coordinate width comes from the parameter.
interface aat_box_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          box_is_empty;
  logic signed [COORD_WIDTH-1:0] min_x;
  logic signed [COORD_WIDTH-1:0] min_y;
  logic signed [COORD_WIDTH-1:0] min_z;
  logic signed [COORD_WIDTH-1:0] max_x;
  logic signed [COORD_WIDTH-1:0] max_y;
  logic signed [COORD_WIDTH-1:0] max_z;

  modport source (
    output valid, box_is_empty, min_x, min_y, min_z, max_x, max_y, max_z,
    input  ready
  );
  modport sink (
    input  valid, box_is_empty, min_x, min_y, min_z, max_x, max_y, max_z,
    output ready
  );
endinterface

>>> rtl/core/aat_res_if.sv
// Result channel of the box transform block: one transformed box per item.
// Standalone; the coordinate width comes from the parameter.
interface aat_res_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          result_is_empty;
  logic signed [COORD_WIDTH-1:0] out_min_x;
  logic signed [COORD_WIDTH-1:0] out_min_y;
  logic signed [COORD_WIDTH-1:0] out_min_z;
  logic signed [COORD_WIDTH-1:0] out_max_x;
  logic signed [COORD_WIDTH-1:0] out_max_y;
  logic signed [COORD_WIDTH-1:0] out_max_z;
  logic                          saturated;

  modport source (
    output valid, result_is_empty, out_min_x, out_min_y, out_min_z,
           out_max_x, out_max_y, out_max_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, result_is_empty, out_min_x, out_min_y, out_min_z,
           out_max_x, out_max_y, out_max_z, saturated,
    output ready
  );
endinterface

>>> rtl/core/aabb_affine_transform.sv
// Affine transform of an axis-aligned box; uses aat_pkg, aat_box_if, aat_res_if.
// Items pass through the input, product, sum and result registers in turn.
// Throughput: one item per cycle while results are taken; the four registers
// advance independently, so bubbles close up and a stalled result holds only
// the stages behind it.
// Reset clears all valid flags and loads the identity matrix.
module aabb_affine_transform #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aat_pkg::PADDR_W-1:0]  paddr,
  input  logic [aat_pkg::PDATA_W-1:0]  pwdata,
  output logic [aat_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  aat_box_if.sink                      box_i,
  aat_res_if.source                    res_o
);
  import aat_pkg::*;

  localparam int ProdW = COEF_W + COORD_WIDTH;
  localparam int AccW  = (COORD_WIDTH > FRAC_BITS ? COORD_WIDTH : FRAC_BITS) + COEF_W + 2;

  // Configuration registers
  aat_cfg_t cfg_q [NUM_REGS];
  aat_reg_e cfg_idx;
  logic     cfg_wr;

  assign cfg_idx = aat_reg_e'(paddr[PADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ROW0_C01: cfg_q[0] <= pwdata;
        REG_ROW0_C23: cfg_q[1] <= pwdata;
        REG_ROW1_C01: cfg_q[2] <= pwdata;
        REG_ROW1_C23: cfg_q[3] <= pwdata;
        REG_ROW2_C01: cfg_q[4] <= pwdata;
        REG_ROW2_C23: cfg_q[5] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ROW0_C01: prdata = cfg_q[0];
      REG_ROW0_C23: prdata = cfg_q[1];
      REG_ROW1_C01: prdata = cfg_q[2];
      REG_ROW1_C23: prdata = cfg_q[3];
      REG_ROW2_C01: prdata = cfg_q[4];
      REG_ROW2_C23: prdata = cfg_q[5];
      default:      prdata = '0;
    endcase
  end

  // Matrix coefficients and translations, one row per output axis.
  logic signed [COEF_W-1:0] coef  [ROWS][ROWS];
  logic signed [COEF_W-1:0] trans [ROWS];

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      coef[r][0] = cfg_q[2*r][COEF_W-1:0];
      coef[r][1] = cfg_q[2*r][PDATA_W-1:COEF_W];
      coef[r][2] = cfg_q[2*r+1][COEF_W-1:0];
      trans[r]   = cfg_q[2*r+1][PDATA_W-1:COEF_W];
    end
  end

  // Stage flow control
  logic v0_q, v1_q, v2_q, vo_q;
  logic adv0, adv1, adv2, adv3;

  assign adv3        = !vo_q || res_o.ready;
  assign adv2        = !v2_q || adv3;
  assign adv1        = !v1_q || adv2;
  assign adv0        = !v0_q || adv1;
  assign box_i.ready = adv0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv0) v0_q <= box_i.valid;
      if (adv1) v1_q <= v0_q;
      if (adv2) v2_q <= v1_q;
      if (adv3) vo_q <= v2_q;
    end
  end

  // Input register
  logic                          e0_q;
  logic signed [COORD_WIDTH-1:0] lo0_q [ROWS];
  logic signed [COORD_WIDTH-1:0] hi0_q [ROWS];

  always_ff @(posedge clk_i) begin
    if (adv0) begin
      e0_q     <= box_i.box_is_empty;
      lo0_q[0] <= box_i.min_x;
      lo0_q[1] <= box_i.min_y;
      lo0_q[2] <= box_i.min_z;
      hi0_q[0] <= box_i.max_x;
      hi0_q[1] <= box_i.max_y;
      hi0_q[2] <= box_i.max_z;
    end
  end

  // Product register: each coefficient times both ends of its column.
  logic                    e1_q;
  logic signed [ProdW-1:0] pa1_q [ROWS][ROWS];
  logic signed [ProdW-1:0] pb1_q [ROWS][ROWS];
  logic signed [AccW-1:0]  t1_q  [ROWS];

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      e1_q <= e0_q;
      for (int r = 0; r < ROWS; r++) begin
        t1_q[r] <= AccW'(trans[r]) <<< FRAC_BITS;
        for (int j = 0; j < ROWS; j++) begin
          pa1_q[r][j] <= ProdW'(coef[r][j]) * ProdW'(lo0_q[j]);
          pb1_q[r][j] <= ProdW'(coef[r][j]) * ProdW'(hi0_q[j]);
        end
      end
    end
  end

  // Sum register: the smaller product of each column goes to the lower bound.
  logic                   e2_q;
  logic signed [AccW-1:0] lo2_q [ROWS];
  logic signed [AccW-1:0] hi2_q [ROWS];
  logic signed [AccW-1:0] lo_sel [ROWS][ROWS];
  logic signed [AccW-1:0] hi_sel [ROWS][ROWS];

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int j = 0; j < ROWS; j++) begin
        if (pa1_q[r][j] <= pb1_q[r][j]) begin
          lo_sel[r][j] = AccW'(pa1_q[r][j]);
          hi_sel[r][j] = AccW'(pb1_q[r][j]);
        end else begin
          lo_sel[r][j] = AccW'(pb1_q[r][j]);
          hi_sel[r][j] = AccW'(pa1_q[r][j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      e2_q <= e1_q;
      for (int r = 0; r < ROWS; r++) begin
        lo2_q[r] <= t1_q[r] + lo_sel[r][0] + lo_sel[r][1] + lo_sel[r][2];
        hi2_q[r] <= t1_q[r] + hi_sel[r][0] + hi_sel[r][1] + hi_sel[r][2];
      end
    end
  end

  // Drops the fraction bits (rounding down) and clamps; the top bit flags a clamp.
  function automatic logic [COORD_WIDTH:0] clamp(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0]       sh;
    logic [AccW-COORD_WIDTH:0]    top;
    sh  = acc >>> FRAC_BITS;
    top = sh[AccW-1:COORD_WIDTH-1];
    if (top == '0 || top == '1) begin
      return {1'b0, sh[COORD_WIDTH-1:0]};
    end else if (sh[AccW-1]) begin
      return {1'b1, 1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  endfunction

  logic [COORD_WIDTH:0] lo_c [ROWS];
  logic [COORD_WIDTH:0] hi_c [ROWS];
  logic                 any_sat;

  always_comb begin
    any_sat = 1'b0;
    for (int r = 0; r < ROWS; r++) begin
      lo_c[r] = clamp(lo2_q[r]);
      hi_c[r] = clamp(hi2_q[r]);
      any_sat = any_sat | lo_c[r][COORD_WIDTH] | hi_c[r][COORD_WIDTH];
    end
  end

  // Result register
  logic                   empty_q;
  logic                   sat_q;
  logic [COORD_WIDTH-1:0] omin_q [ROWS];
  logic [COORD_WIDTH-1:0] omax_q [ROWS];

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      empty_q <= e2_q;
      sat_q   <= e2_q ? 1'b0 : any_sat;
      for (int r = 0; r < ROWS; r++) begin
        omin_q[r] <= e2_q ? '0 : lo_c[r][COORD_WIDTH-1:0];
        omax_q[r] <= e2_q ? '0 : hi_c[r][COORD_WIDTH-1:0];
      end
    end
  end

  assign res_o.valid           = vo_q;
  assign res_o.result_is_empty = empty_q;
  assign res_o.saturated       = sat_q;
  assign res_o.out_min_x       = omin_q[0];
  assign res_o.out_min_y       = omin_q[1];
  assign res_o.out_min_z       = omin_q[2];
  assign res_o.out_max_x       = omax_q[0];
  assign res_o.out_max_y       = omax_q[1];
  assign res_o.out_max_z       = omax_q[2];

endmodule

>>> rtl/core/aat_checker.sv
// Port-level checks of the box transform block, bound to the top level.
// Uses aat_pkg and the macros in aabb_affine_transform_assert.svh.
`include "aabb_affine_transform_assert.svh"

module aat_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         psel_i,
  input logic                         penable_i,
  input logic                         pwrite_i,
  input logic [aat_pkg::PADDR_W-1:0]  paddr_i,
  input logic [aat_pkg::PDATA_W-1:0]  pwdata_i,
  input logic [aat_pkg::PDATA_W-1:0]  prdata_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         out_empty_i,
  input logic                         out_sat_i,
  input logic [COORD_WIDTH-1:0]       out_min_x_i,
  input logic [COORD_WIDTH-1:0]       out_min_y_i,
  input logic [COORD_WIDTH-1:0]       out_min_z_i,
  input logic [COORD_WIDTH-1:0]       out_max_x_i,
  input logic [COORD_WIDTH-1:0]       out_max_y_i,
  input logic [COORD_WIDTH-1:0]       out_max_z_i
);
  import aat_pkg::*;

  logic stalled, res_full, res_null, all_zero, ordered, known_wr, same_addr, rd_back;
  logic [PADDR_W-4:0] addr_prev_q;
  logic [PDATA_W-1:0] wdata_prev_q;

  // Address and write data of the previous cycle, for the readback check.
  always_ff @(posedge clk_i) begin
    addr_prev_q  <= paddr_i[PADDR_W-1:3];
    wdata_prev_q <= pwdata_i;
  end

  assign stalled  = out_valid_i && !out_ready_i;
  assign res_full = out_valid_i && !out_empty_i;
  assign res_null = out_valid_i && out_empty_i;
  assign all_zero = out_min_x_i == '0 && out_min_y_i == '0 && out_min_z_i == '0 &&
                    out_max_x_i == '0 && out_max_y_i == '0 && out_max_z_i == '0 &&
                    !out_sat_i;
  assign ordered  = $signed(out_min_x_i) <= $signed(out_max_x_i) &&
                    $signed(out_min_y_i) <= $signed(out_max_y_i) &&
                    $signed(out_min_z_i) <= $signed(out_max_z_i);
  assign known_wr = psel_i && penable_i && pwrite_i &&
                    ({1'b0, paddr_i[PADDR_W-1:3]} < 4'(NUM_REGS));
  assign same_addr = paddr_i[PADDR_W-1:3] == addr_prev_q;
  assign rd_back  = prdata_i == wdata_prev_q;

  // A shown result stays until it is taken.
  `AAT_ASSERT_NXT(a_res_hold, clk_i, rst_ni, stalled, out_valid_i, "result dropped while stalled")
  // An empty box comes out with all coordinates and the clamp flag at zero.
  `AAT_ASSERT_IMP(a_empty_zero, clk_i, rst_ni, res_null, all_zero, "empty result not zeroed")
  // Lower bounds never exceed upper bounds, clamped or not.
  `AAT_ASSERT_IMP(a_min_le_max, clk_i, rst_ni, res_full, ordered, "lower bound above upper")
  // A register written reads back its new value in the next cycle.
  `AAT_ASSERT_IMP(a_cfg_rdback, clk_i, rst_ni, known_wr ##1 same_addr, rd_back, "readback")

endmodule

bind aabb_affine_transform aat_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_aat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .psel_i      (psel),
  .penable_i   (penable),
  .pwrite_i    (pwrite),
  .paddr_i     (paddr),
  .pwdata_i    (pwdata),
  .prdata_i    (prdata),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_empty_i (res_o.result_is_empty),
  .out_sat_i   (res_o.saturated),
  .out_min_x_i (res_o.out_min_x),
  .out_min_y_i (res_o.out_min_y),
  .out_min_z_i (res_o.out_min_z),
  .out_max_x_i (res_o.out_max_x),
  .out_max_y_i (res_o.out_max_y),
  .out_max_z_i (res_o.out_max_z)
);

>>> bench/tb.sv
// Self-checking bench for aabb_affine_transform: boxes go in, transformed bounds are
// predicted in fixed point and compared field by field as they come out.
// Depends on aat_pkg, aat_box_if, aat_res_if and the block itself.
`timescale 1ns / 1ps

module tb;
  import aat_pkg::*;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int ACC_W   = 72;
  localparam int LATENCY = 4;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0]   ACC_MAX   = (ACC_W'(1) << (COORD_W-1)) - 1;
  localparam logic signed [ACC_W-1:0]   ACC_MIN   = -(ACC_W'(1) << (COORD_W-1));
  localparam logic [PADDR_W-1:0]        UNMAPPED_A = 6'd48;
  localparam logic [PADDR_W-1:0]        UNMAPPED_B = 6'd56;

  typedef enum int {MAT_SMALL, MAT_FULL, MAT_MIXED, MAT_ZERO, MAT_ONES, MAT_EDGE} mat_mode_e;

  typedef struct {
    logic                      empty;
    logic signed [COORD_W-1:0] lo [3];
    logic signed [COORD_W-1:0] hi [3];
  } box_t;

  typedef struct {
    logic                      empty;
    logic signed [COORD_W-1:0] lo [3];
    logic signed [COORD_W-1:0] hi [3];
    logic                      sat;
  } bounds_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;

  aat_box_if #(.COORD_WIDTH(COORD_W)) box_if ();
  aat_res_if #(.COORD_WIDTH(COORD_W)) res_if ();

  aabb_affine_transform #(
    .COORD_WIDTH(COORD_W),
    .FRAC_BITS  (FRAC_W)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .box_i  (box_if),
    .res_o  (res_if)
  );

  aat_cfg_t matrix_regs [NUM_REGS];
  bounds_t  pending_bounds [$];
  int       mismatches;
  bit       src_idle_en;
  bit       snk_idle_en;
  int       hold_request;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Predicted output coordinate: one floor shift, then clamp to the coordinate range.
  function automatic logic signed [COORD_W-1:0] clamp_coord(
    input  logic signed [ACC_W-1:0] acc,
    output logic                    clipped
  );
    logic signed [ACC_W-1:0] shifted;
    shifted = acc >>> FRAC_W;
    clipped = 1'b1;
    if (shifted > ACC_MAX) return COORD_MAX;
    if (shifted < ACC_MIN) return COORD_MIN;
    clipped = 1'b0;
    return shifted[COORD_W-1:0];
  endfunction

  // Each output bound is the translation plus, per column, the smaller or the larger
  // of the two corner products, which equals the extreme over all eight corners.
  function automatic bounds_t transform_box(box_t b);
    bounds_t                   r;
    logic signed [COEF_W-1:0]  coef [3];
    logic signed [ACC_W-1:0]   lo_acc, hi_acc, p_lo, p_hi;
    logic                      clipped;
    r.empty = b.empty;
    r.sat   = 1'b0;
    for (int a = 0; a < 3; a++) begin
      r.lo[a] = '0;
      r.hi[a] = '0;
    end
    if (b.empty) return r;
    for (int row = 0; row < ROWS; row++) begin
      coef[0] = matrix_regs[2*row][31:0];
      coef[1] = matrix_regs[2*row][63:32];
      coef[2] = matrix_regs[2*row+1][31:0];
      lo_acc  = $signed(matrix_regs[2*row+1][63:32]);
      lo_acc  = lo_acc <<< FRAC_W;
      hi_acc  = lo_acc;
      for (int c = 0; c < 3; c++) begin
        p_lo = coef[c] * b.lo[c];
        p_hi = coef[c] * b.hi[c];
        if (p_lo <= p_hi) begin
          lo_acc += p_lo;
          hi_acc += p_hi;
        end else begin
          lo_acc += p_hi;
          hi_acc += p_lo;
        end
      end
      r.lo[row] = clamp_coord(lo_acc, clipped);
      r.sat |= clipped;
      r.hi[row] = clamp_coord(hi_acc, clipped);
      r.sat |= clipped;
    end
    return r;
  endfunction

  function automatic box_t make_box(logic e, logic signed [COORD_W-1:0] x0, y0, z0, x1, y1, z1);
    box_t b;
    b.empty = e;
    b.lo    = '{x0, y0, z0};
    b.hi    = '{x1, y1, z1};
    return b;
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    logic signed [COORD_W-1:0] v;
    v = $urandom;
    case ($urandom_range(0, 4))
      0: return v;
      1: return v >>> $urandom_range(4, 31);
      2: return {{12{v[19]}}, v[19:0]};
      3: return {{16{v[15]}}, v[15:0]};
      default: begin
        case ($urandom_range(0, 4))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
    endcase
  endfunction

  // Mostly well-ordered boxes; some with swapped corners and a few empty ones.
  function automatic box_t rand_box();
    box_t                      b;
    logic signed [COORD_W-1:0] t;
    b.empty = ($urandom_range(0, 11) == 0);
    for (int a = 0; a < 3; a++) begin
      b.lo[a] = rand_coord();
      b.hi[a] = rand_coord();
      if ($urandom_range(0, 3) != 0 && b.lo[a] > b.hi[a]) begin
        t       = b.lo[a];
        b.lo[a] = b.hi[a];
        b.hi[a] = t;
      end
    end
    return b;
  endfunction

  function automatic logic [31:0] rand_half(mat_mode_e mode);
    logic [31:0] v;
    v = $urandom;
    case (mode)
      MAT_SMALL: return {{14{v[17]}}, v[17:0]};
      MAT_FULL:  return v;
      MAT_ZERO:  return '0;
      MAT_ONES:  return '1;
      MAT_EDGE:  return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: begin
        case ($urandom_range(0, 3))
          0: return v;
          1: return {{14{v[17]}}, v[17:0]};
          2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
    mismatches++;
    if (mismatches <= 50)
      $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  // One write: setup phase, then access phase. psel is left high so that writes can
  // follow one another; load_matrix drops it.
  task automatic write_reg(logic [PADDR_W-1:0] addr, aat_cfg_t data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[2:0] == 3'b000 && addr[PADDR_W-1:3] < NUM_REGS)
      matrix_regs[addr[PADDR_W-1:3]] = data;
  endtask

  task automatic load_matrix(aat_cfg_t m [NUM_REGS]);
    aat_reg_e r;
    r = r.first();
    do begin
      write_reg({r, 3'b000}, m[r]);
      r = r.next();
    end while (r != r.first());
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offers one box, with an optional random gap first, and records its prediction
  // at the edge where it is taken. valid is left high for a following item.
  task automatic send_box(box_t b);
    int n;
    if (src_idle_en && $urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 19);
      box_if.valid        <= 1'b0;
      box_if.box_is_empty <= 1'($urandom);
      box_if.min_x        <= $urandom;
      box_if.max_z        <= $urandom;
      repeat (n) @(posedge clk_i);
    end
    box_if.valid        <= 1'b1;
    box_if.box_is_empty <= b.empty;
    box_if.min_x        <= b.lo[0];
    box_if.min_y        <= b.lo[1];
    box_if.min_z        <= b.lo[2];
    box_if.max_x        <= b.hi[0];
    box_if.max_y        <= b.hi[1];
    box_if.max_z        <= b.hi[2];
    do @(posedge clk_i); while (!box_if.ready);
    pending_bounds.push_back(transform_box(b));
  endtask

  task automatic wait_drained();
    box_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_bounds.size() != 0);
  endtask

  task automatic test_identity_extremes();
    send_box(make_box(1'b0, 0, 0, 0, 0, 0, 0));
    send_box(make_box(1'b0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(make_box(1'b0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
    send_box(make_box(1'b1, COORD_MIN, COORD_MAX, -1, COORD_MAX, COORD_MIN, 1));
    send_box(make_box(1'b1, 0, 0, 0, 0, 0, 0));
    send_box(make_box(1'b0, -1, -1, -1, 1, 1, 1));
    send_box(make_box(1'b0, 32'h1234_5678, -32'sd77, 32'h0001_8000,
                      32'h0765_4321, 32'sd99, -32'sd3));
    send_box(make_box(1'b0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(make_box(1'b0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
  endtask

  // Half scale on x shows the floor on negative fractions; the other rows are built
  // to saturate both ways. Writes to unmapped addresses must leave the matrix alone.
  task automatic test_matrix_extremes();
    aat_cfg_t m [NUM_REGS];
    wait_drained();
    write_reg(UNMAPPED_A, '1);
    m[REG_ROW0_C01] = {32'h0000_0000, 32'h0000_8000};
    m[REG_ROW0_C23] = {32'h0000_0000, 32'h0000_0000};
    m[REG_ROW1_C01] = {32'h7fff_ffff, 32'h8000_0000};
    m[REG_ROW1_C23] = {32'h7fff_ffff, 32'h7fff_ffff};
    m[REG_ROW2_C01] = {32'h8000_0000, 32'h8000_0000};
    m[REG_ROW2_C23] = {32'h8000_0000, 32'h8000_0000};
    load_matrix(m);
    @(posedge clk_i);
    write_reg(UNMAPPED_B, '1);
    psel    <= 1'b0;
    penable <= 1'b0;
    send_box(make_box(1'b0, 0, 0, 0, 0, 0, 0));
    send_box(make_box(1'b0, -1, -1, -1, 1, 1, 1));
    send_box(make_box(1'b0, -3, 5, -7, -3, 5, -7));
    send_box(make_box(1'b0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(make_box(1'b0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN));
    send_box(make_box(1'b0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(make_box(1'b0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_box(make_box(1'b1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_box(make_box(1'b0, 32'h0000_ffff, -32'sd65537, 32'sd1, 32'h0001_0001, 32'sd4, 32'sd2));
  endtask

  // The receiver holds off long enough for the pipeline to fill and refuse input.
  task automatic test_result_backpressure();
    wait_drained();
    src_idle_en  = 1'b0;
    hold_request = 120;
    repeat (24) send_box(rand_box());
    src_idle_en = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (15) send_box(rand_box());
    wait_drained();
    repeat (15) send_box(rand_box());
  endtask

  task automatic test_random_phase(mat_mode_e mode, int count);
    aat_cfg_t m [NUM_REGS];
    wait_drained();
    foreach (m[i]) m[i] = {rand_half(mode), rand_half(mode)};
    load_matrix(m);
    repeat (count) send_box(rand_box());
  endtask

  initial begin
    int n;
    int k;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request > 0) begin
        n            = hold_request;
        hold_request = 0;
        res_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        if (snk_idle_en && $urandom_range(0, 5) == 0) begin
          res_if.ready <= 1'b0;
          n = $urandom_range(1, 19);
        end else begin
          res_if.ready <= 1'b1;
          n = $urandom_range(1, 40);
        end
        k = 0;
        do begin
          @(posedge clk_i);
          k++;
        end while (k < n && hold_request == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    bounds_t                   want;
    logic signed [COORD_W-1:0] got_lo [3];
    logic signed [COORD_W-1:0] got_hi [3];
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_bounds.size() == 0) begin
        report_mismatch("unexpected item", '0, '0);
      end else begin
        want   = pending_bounds.pop_front();
        got_lo = '{res_if.out_min_x, res_if.out_min_y, res_if.out_min_z};
        got_hi = '{res_if.out_max_x, res_if.out_max_y, res_if.out_max_z};
        if (res_if.result_is_empty !== want.empty)
          report_mismatch("result_is_empty", COORD_W'(res_if.result_is_empty),
                          COORD_W'(want.empty));
        if (res_if.saturated !== want.sat)
          report_mismatch("saturated", COORD_W'(res_if.saturated), COORD_W'(want.sat));
        // Axis letters x, y and z are consecutive in ASCII.
        for (int a = 0; a < 3; a++) begin
          if (got_lo[a] !== want.lo[a])
            report_mismatch($sformatf("out_min_%c", 8'h78 + a), got_lo[a], want.lo[a]);
          if (got_hi[a] !== want.hi[a])
            report_mismatch($sformatf("out_max_%c", 8'h78 + a), got_hi[a], want.hi[a]);
        end
      end
    end
  end

  initial begin
    mismatches   = 0;
    hold_request = 0;
    src_idle_en  = 1'b1;
    snk_idle_en  = 1'b1;
    matrix_regs  = CFG_RESET;
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    box_if.valid        <= 1'b0;
    box_if.box_is_empty <= 1'b0;
    box_if.min_x        <= '0;
    box_if.min_y        <= '0;
    box_if.min_z        <= '0;
    box_if.max_x        <= '0;
    box_if.max_y        <= '0;
    box_if.max_z        <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_identity_extremes();
    test_matrix_extremes();
    test_result_backpressure();
    test_sender_pause();
    test_random_phase(MAT_SMALL, 400);
    test_random_phase(MAT_FULL, 300);
    test_random_phase(MAT_ZERO, 100);
    test_random_phase(MAT_ONES, 100);
    test_random_phase(MAT_EDGE, 200);
    test_random_phase(MAT_MIXED, 300);
    wait_drained();
    src_idle_en = 1'b0;
    snk_idle_en = 1'b0;
    test_random_phase(MAT_SMALL, 400);

    wait_drained();
    repeat (LATENCY + 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/aat_pkg.sv
rtl/core/aat_box_if.sv
rtl/core/aat_res_if.sv
rtl/core/aabb_affine_transform.sv
rtl/core/aat_checker.sv
bench/tb.sv
